// ===== sv/tpbe_pkg.sv =====
// ----------------------------------------------------------------------------
// tpbe_pkg
// Types and constants for the tape pulse block encoder.
// ----------------------------------------------------------------------------
package tpbe_pkg;

   localparam int unsigned HEADER_BYTES      = 193;
   localparam int unsigned BLOCK_SYNC_PULSES = 79;
   localparam int unsigned FRAME_PULSES      = 20;
   localparam int unsigned EOD_PULSES        = 2;
   localparam int unsigned SETTLE_STEPS      = 3;

   localparam logic [3:0] COUNTDOWN_START = 4'd9;
   localparam logic [7:0] FIRST_COPY_MARK = 8'h80;

   localparam logic [7:0]  SHORT_RESET       = 8'd47;
   localparam logic [7:0]  MEDIUM_RESET      = 8'd66;
   localparam logic [7:0]  LONG_RESET        = 8'd87;
   localparam logic [15:0] LEADER_RESET      = 16'h6A00;
   localparam logic [15:0] DATA_LEADER_RESET = 16'h1500;
   localparam logic [15:0] PAYLOAD_RESET     = 16'd0;

   typedef enum logic [2:0] {
      CSR_SHORT       = 3'd0,
      CSR_MEDIUM      = 3'd1,
      CSR_LONG        = 3'd2,
      CSR_LEADER      = 3'd3,
      CSR_DATA_LEADER = 3'd4,
      CSR_PAYLOAD_LEN = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_RESTART = 2'd0,
      OP_NEXT    = 2'd1,
      OP_SUPPLY  = 2'd2,
      OP_NOP     = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_PULSE   = 3'd0,
      KIND_SILENCE = 3'd1,
      KIND_NEED    = 3'd2,
      KIND_ACCEPT  = 3'd3,
      KIND_IDLE    = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_LEADER  = 4'd1,
      PH_HCOUNT  = 4'd2,
      PH_HBYTES  = 4'd3,
      PH_HEOD    = 4'd4,
      PH_HSYNC   = 4'd5,
      PH_SILENCE = 4'd6,
      PH_DLEADER = 4'd7,
      PH_DCOUNT  = 4'd8,
      PH_DBYTES  = 4'd9,
      PH_CHECK   = 4'd10,
      PH_DEOD    = 4'd11,
      PH_DSYNC   = 4'd12,
      PH_DONE    = 4'd13
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic        copy_round;
      logic [4:0]  pulse_slot;
      logic [7:0]  held_byte;
      logic        byte_loaded;
      logic [15:0] byte_count;
      logic [15:0] pulse_count;
      logic [7:0]  checksum;
      logic [3:0]  countdown;
   } seq_state_type;

   localparam seq_state_type SEQ_RESET = '{
      phase:       PH_IDLE,
      copy_round:  1'b0,
      pulse_slot:  5'd0,
      held_byte:   8'd0,
      byte_loaded: 1'b0,
      byte_count:  16'd0,
      pulse_count: 16'd0,
      checksum:    8'd0,
      countdown:   COUNTDOWN_START
   };

endpackage

// ===== sv/tape_pulse_block_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// tape_pulse_block_encoder_unit
// Sequencer that emits a tape image as pulse-length codes, one response per request.
// ----------------------------------------------------------------------------
//  port group | dir | fields (low bit first)             | handshake
//  req_       | in  | tdata: data_byte[7:0]; tuser: op    | tvalid/tready
//  rsp_       | out | tdata: pulse_code[7:0]; tuser: kind | tvalid/tready
//  csr_       | in  | index 0..5, data 16 bits            | csr_we
//
//  One word per cycle while req_tready is high: each word loads the response
//  register, and each word but a NOP updates the sequence state, in the cycle it is accepted.
//  req_tready is high while the response register is empty or being drained.
//  Synchronous reset returns the CSRs to defaults, clears the response valid and the sequence to idle.
module tape_pulse_block_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // data_byte[7:0]
   input  logic [1:0]  req_tuser,    // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // pulse_code[7:0]
   output logic [2:0]  rsp_tuser,    // result_kind[2:0]
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   logic [7:0]  short_ff, medium_ff, long_ff;
   logic [15:0] leader_ff, dleader_ff, plen_ff;

   tpbe_pkg::seq_state_type st_ff, st_in, st_base, st_pre, st_act;
   tpbe_pkg::op_type        op;
   tpbe_pkg::kind_type      kind_c;
   logic [7:0]  code_c;
   logic [7:0]  frame_byte;
   logic [7:0]  frame_code;
   logic [4:0]  slot_next;
   logic        accept;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_code_ff;
   logic [2:0]  rsp_kind_ff;

   // one transition of the section sequencer, if the current section is complete
   function automatic tpbe_pkg::seq_state_type settle_step(
      input tpbe_pkg::seq_state_type s,
      input logic [15:0] lp,
      input logic [15:0] dlp,
      input logic [15:0] plen
   );
      tpbe_pkg::seq_state_type r;
      r = s;
      unique case (s.phase)
         tpbe_pkg::PH_LEADER: begin
            if (s.pulse_count >= lp) begin
               r.phase = tpbe_pkg::PH_HCOUNT;
               r.countdown = tpbe_pkg::COUNTDOWN_START;
               r.pulse_slot = 5'd0;
            end
         end
         tpbe_pkg::PH_HCOUNT, tpbe_pkg::PH_DCOUNT: begin
            if (s.countdown == 4'd0) begin
               r.phase = (s.phase == tpbe_pkg::PH_HCOUNT) ?
                         tpbe_pkg::PH_HBYTES : tpbe_pkg::PH_DBYTES;
               r.byte_count = 16'd0;
               r.pulse_slot = 5'd0;
               r.byte_loaded = 1'b0;
            end
         end
         tpbe_pkg::PH_HBYTES: begin
            if (s.byte_count >= 16'(tpbe_pkg::HEADER_BYTES)) begin
               r.phase = tpbe_pkg::PH_HEOD;
               r.pulse_slot = 5'd0;
            end
         end
         tpbe_pkg::PH_HEOD, tpbe_pkg::PH_DEOD: begin
            if (s.pulse_slot >= 5'(tpbe_pkg::EOD_PULSES)) begin
               r.phase = (s.phase == tpbe_pkg::PH_HEOD) ?
                         tpbe_pkg::PH_HSYNC : tpbe_pkg::PH_DSYNC;
               r.pulse_count = 16'd0;
            end
         end
         tpbe_pkg::PH_HSYNC: begin
            if (s.pulse_count >= 16'(tpbe_pkg::BLOCK_SYNC_PULSES)) begin
               if (!s.copy_round) begin
                  r.copy_round = 1'b1;
                  r.phase = tpbe_pkg::PH_HCOUNT;
                  r.countdown = tpbe_pkg::COUNTDOWN_START;
                  r.pulse_slot = 5'd0;
               end else begin
                  r.copy_round = 1'b0;
                  r.phase = tpbe_pkg::PH_SILENCE;
               end
            end
         end
         tpbe_pkg::PH_DLEADER: begin
            if (s.pulse_count >= dlp) begin
               r.phase = tpbe_pkg::PH_DCOUNT;
               r.countdown = tpbe_pkg::COUNTDOWN_START;
               r.pulse_slot = 5'd0;
               r.checksum = 8'd0;
            end
         end
         tpbe_pkg::PH_DBYTES: begin
            if (s.byte_count >= plen) begin
               r.phase = tpbe_pkg::PH_CHECK;
               r.pulse_slot = 5'd0;
            end
         end
         tpbe_pkg::PH_DSYNC: begin
            if (s.pulse_count >= 16'(tpbe_pkg::BLOCK_SYNC_PULSES)) begin
               if (!s.copy_round) begin
                  r.copy_round = 1'b1;
                  r.phase = tpbe_pkg::PH_DCOUNT;
                  r.countdown = tpbe_pkg::COUNTDOWN_START;
                  r.pulse_slot = 5'd0;
                  r.checksum = 8'd0;
               end else begin
                  r.phase = tpbe_pkg::PH_DONE;
               end
            end
         end
         default: r = s;
      endcase
      return r;
   endfunction

   function automatic tpbe_pkg::seq_state_type settle(
      input tpbe_pkg::seq_state_type s,
      input logic [15:0] lp,
      input logic [15:0] dlp,
      input logic [15:0] plen
   );
      tpbe_pkg::seq_state_type r;
      r = s;
      for (int i = 0; i < tpbe_pkg::SETTLE_STEPS; i++) begin
         r = settle_step(r, lp, dlp, plen);
      end
      return r;
   endfunction

   // pulse of the 20-pulse byte frame: marker, eight bit pairs, parity pair
   function automatic logic [7:0] frame_pulse(
      input logic [7:0] b,
      input logic [4:0] slot,
      input logic [7:0] sc,
      input logic [7:0] mc,
      input logic [7:0] lc
   );
      logic [4:0] rel;
      logic       bit_v;
      logic [7:0] r;
      rel = slot - 5'd2;
      if (slot < 5'd18) begin
         bit_v = b[rel[3:1]];
      end else begin
         bit_v = ~(^b);
      end
      if (slot == 5'd0) begin
         r = lc;
      end else if (slot == 5'd1) begin
         r = mc;
      end else if (!slot[0]) begin
         r = bit_v ? mc : sc;
      end else begin
         r = bit_v ? sc : mc;
      end
      return r;
   endfunction

   assign op     = tpbe_pkg::op_type'(req_tuser);
   assign accept = req_tvalid && req_tready;

   always_comb begin
      st_base = st_ff;
      if (op == tpbe_pkg::OP_RESTART) begin
         st_base = tpbe_pkg::SEQ_RESET;
         st_base.phase = tpbe_pkg::PH_LEADER;
      end
   end

   assign st_pre = settle(st_base, leader_ff, dleader_ff, plen_ff);

   always_comb begin
      if (st_pre.phase == tpbe_pkg::PH_HCOUNT || st_pre.phase == tpbe_pkg::PH_DCOUNT) begin
         frame_byte = (st_pre.copy_round ? 8'h00 : tpbe_pkg::FIRST_COPY_MARK) |
                      {4'd0, st_pre.countdown};
      end else if (st_pre.phase == tpbe_pkg::PH_CHECK) begin
         frame_byte = st_pre.checksum;
      end else begin
         frame_byte = st_pre.held_byte;
      end
   end

   assign frame_code = frame_pulse(frame_byte, st_pre.pulse_slot, short_ff, medium_ff, long_ff);
   assign slot_next  = st_pre.pulse_slot + 5'd1;

   // next state
   always_comb begin
      st_act = st_pre;
      unique case (op)
         tpbe_pkg::OP_RESTART: st_act = st_pre;
         tpbe_pkg::OP_SUPPLY: begin
            if ((st_pre.phase == tpbe_pkg::PH_HBYTES || st_pre.phase == tpbe_pkg::PH_DBYTES)
                && !st_pre.byte_loaded) begin
               st_act.held_byte = req_tdata;
               st_act.byte_loaded = 1'b1;
               if (st_pre.phase == tpbe_pkg::PH_DBYTES) begin
                  st_act.checksum = st_pre.checksum ^ req_tdata;
               end
            end
         end
         tpbe_pkg::OP_NEXT: begin
            unique case (st_pre.phase)
               tpbe_pkg::PH_LEADER, tpbe_pkg::PH_HSYNC,
               tpbe_pkg::PH_DLEADER, tpbe_pkg::PH_DSYNC: begin
                  st_act.pulse_count = st_pre.pulse_count + 16'd1;
               end
               tpbe_pkg::PH_HEOD, tpbe_pkg::PH_DEOD: begin
                  st_act.pulse_slot = slot_next;
               end
               tpbe_pkg::PH_SILENCE: begin
                  st_act.phase = tpbe_pkg::PH_DLEADER;
                  st_act.pulse_count = 16'd0;
                  st_act.copy_round = 1'b0;
               end
               tpbe_pkg::PH_HCOUNT, tpbe_pkg::PH_HBYTES, tpbe_pkg::PH_DCOUNT,
               tpbe_pkg::PH_DBYTES, tpbe_pkg::PH_CHECK: begin
                  if (!((st_pre.phase == tpbe_pkg::PH_HBYTES ||
                         st_pre.phase == tpbe_pkg::PH_DBYTES) && !st_pre.byte_loaded)) begin
                     st_act.pulse_slot = slot_next;
                     if (slot_next >= 5'(tpbe_pkg::FRAME_PULSES)) begin
                        st_act.pulse_slot = 5'd0;
                        st_act.byte_loaded = 1'b0;
                        if (st_pre.phase == tpbe_pkg::PH_HCOUNT ||
                            st_pre.phase == tpbe_pkg::PH_DCOUNT) begin
                           st_act.countdown = st_pre.countdown - 4'd1;
                        end else if (st_pre.phase == tpbe_pkg::PH_CHECK) begin
                           st_act.phase = tpbe_pkg::PH_DEOD;
                        end else begin
                           st_act.byte_count = st_pre.byte_count + 16'd1;
                        end
                     end
                  end
               end
               default: st_act = st_pre;
            endcase
         end
         tpbe_pkg::OP_NOP: st_act = st_pre;
         default: st_act = st_pre;
      endcase
      if (op == tpbe_pkg::OP_NOP) begin
         st_in = st_ff;
      end else begin
         st_in = settle(st_act, leader_ff, dleader_ff, plen_ff);
      end
   end

   // response
   always_comb begin
      kind_c = tpbe_pkg::KIND_IDLE;
      code_c = 8'd0;
      unique case (op)
         tpbe_pkg::OP_SUPPLY: begin
            if ((st_pre.phase == tpbe_pkg::PH_HBYTES || st_pre.phase == tpbe_pkg::PH_DBYTES)
                && !st_pre.byte_loaded) begin
               kind_c = tpbe_pkg::KIND_ACCEPT;
            end
         end
         tpbe_pkg::OP_NEXT: begin
            unique case (st_pre.phase)
               tpbe_pkg::PH_LEADER, tpbe_pkg::PH_HSYNC,
               tpbe_pkg::PH_DLEADER, tpbe_pkg::PH_DSYNC: begin
                  kind_c = tpbe_pkg::KIND_PULSE;
                  code_c = short_ff;
               end
               tpbe_pkg::PH_HEOD, tpbe_pkg::PH_DEOD: begin
                  kind_c = tpbe_pkg::KIND_PULSE;
                  code_c = (st_pre.pulse_slot == 5'd0) ? long_ff : short_ff;
               end
               tpbe_pkg::PH_SILENCE: kind_c = tpbe_pkg::KIND_SILENCE;
               tpbe_pkg::PH_HCOUNT, tpbe_pkg::PH_HBYTES, tpbe_pkg::PH_DCOUNT,
               tpbe_pkg::PH_DBYTES, tpbe_pkg::PH_CHECK: begin
                  if ((st_pre.phase == tpbe_pkg::PH_HBYTES ||
                       st_pre.phase == tpbe_pkg::PH_DBYTES) && !st_pre.byte_loaded) begin
                     kind_c = tpbe_pkg::KIND_NEED;
                  end else begin
                     kind_c = tpbe_pkg::KIND_PULSE;
                     code_c = frame_code;
                  end
               end
               default: kind_c = tpbe_pkg::KIND_IDLE;
            endcase
         end
         default: kind_c = tpbe_pkg::KIND_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff   <= tpbe_pkg::SHORT_RESET;
         medium_ff  <= tpbe_pkg::MEDIUM_RESET;
         long_ff    <= tpbe_pkg::LONG_RESET;
         leader_ff  <= tpbe_pkg::LEADER_RESET;
         dleader_ff <= tpbe_pkg::DATA_LEADER_RESET;
         plen_ff    <= tpbe_pkg::PAYLOAD_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            tpbe_pkg::CSR_SHORT:       short_ff   <= csr_wdata[7:0];
            tpbe_pkg::CSR_MEDIUM:      medium_ff  <= csr_wdata[7:0];
            tpbe_pkg::CSR_LONG:        long_ff    <= csr_wdata[7:0];
            tpbe_pkg::CSR_LEADER:      leader_ff  <= csr_wdata;
            tpbe_pkg::CSR_DATA_LEADER: dleader_ff <= csr_wdata;
            tpbe_pkg::CSR_PAYLOAD_LEN: plen_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= tpbe_pkg::SEQ_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            st_ff <= st_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_code_ff <= code_c;
         rsp_kind_ff <= kind_c;
      end
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_code_ff;
   assign rsp_tuser  = rsp_kind_ff;

endmodule
